>>> sv/qrs_pkg.sv
// shared widths, case codes, register indexes and word structs for the quadratic root solver
// no dependencies; imported by every module of the block
package qrs_pkg;

  localparam int COEF_W  = 32;               // coefficient and root width
  localparam int FRAC_W  = 16;               // fraction bits
  localparam int CTOL_W  = 16;               // coefficient tolerance width
  localparam int DTOL_W  = 32;               // discriminant tolerance width
  localparam int PROD_W  = 2 * COEF_W;       // magnitude product width
  localparam int DISC_W  = 2 * COEF_W + 2;   // discriminant magnitude width
  localparam int ROOT_W  = DISC_W / 2;       // square root width
  localparam int REM_W   = ROOT_W + 3;       // square root remainder width
  localparam int NUM_W   = ROOT_W + 2;       // signed numerator width
  localparam int DEN_W   = COEF_W + 1;       // divisor width
  localparam int DIVD_W  = NUM_W + FRAC_W;   // dividend and quotient width
  localparam int IN_W    = 3 * COEF_W;
  localparam int OUT_RAW = 3 + 2 * COEF_W + 1;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 32;

  typedef enum logic [2:0] {
    CASE_INFINITE = 3'd0,
    CASE_NONE     = 3'd1,
    CASE_LINEAR   = 3'd2,
    CASE_TWO      = 3'd3,
    CASE_DOUBLE   = 3'd4,
    CASE_NO_REAL  = 3'd5
  } case_code_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_COEF_TOL = 1'b0,
    REG_DISC_TOL = 1'b1
  } cfg_reg_t;

  // fields carried alongside the square root
  typedef struct packed {
    case_code_t               code;
    logic signed [COEF_W-1:0] b;
    logic                     a_neg;
    logic [COEF_W-1:0]        ma;
    logic [COEF_W-1:0]        mb;
    logic [COEF_W-1:0]        mc;
    logic                     lin_neg;
  } side_t;

  // fields carried alongside the divider
  typedef struct packed {
    case_code_t code;
    logic       neg1;
    logic       neg2;
  } dside_t;

  // clip a quotient magnitude and apply the sign: {sat, root}
  function automatic logic [COEF_W:0] clip_root(input logic [DIVD_W-1:0] q, input logic neg);
    logic [DIVD_W-1:0] lim;
    logic [DIVD_W-1:0] m;
    logic              sat;
    lim = neg ? (DIVD_W'(1) << (COEF_W - 1)) : ((DIVD_W'(1) << (COEF_W - 1)) - DIVD_W'(1));
    sat = q > lim;
    m   = sat ? lim : q;
    return {sat, neg ? (~m[COEF_W-1:0] + 1'b1) : m[COEF_W-1:0]};
  endfunction

endpackage

>>> sv/qrs_front.sv
// front stages: magnitudes and zero tests, products, discriminant and case code
// depends on qrs_pkg
module qrs_front import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic signed [COEF_W-1:0] coef_c,
  input  logic [CTOL_W-1:0]        coef_tol,
  input  logic [DTOL_W-1:0]        disc_tol,
  output logic                     out_valid,
  output logic [DISC_W-1:0]        out_rad,
  output side_t                    out_side
);

  typedef struct packed {
    logic                     za, zb, zc;
    logic                     a_neg, c_neg;
    logic signed [COEF_W-1:0] b;
    logic [COEF_W-1:0]        ma, mb, mc;
    logic                     lin_neg;
  } dec_t;

  logic                      v1_r, v2_r, v3_r;
  dec_t                      d1_r, d1_nxt, d2_r;
  logic [PROD_W-1:0]         bb_r, ac_r;
  logic [DISC_W-1:0]         rad_r, rad_nxt;
  side_t                     side_r, side_nxt;
  logic [DISC_W-1:0]         bb_x, ac4_x;
  logic                      pos;
  logic [COEF_W-1:0]         tol_x;

  // stage one: magnitudes, signs and tolerance tests
  always_comb begin
    tol_x          = COEF_W'(coef_tol);
    d1_nxt.a_neg   = coef_a[COEF_W-1];
    d1_nxt.c_neg   = coef_c[COEF_W-1];
    d1_nxt.b       = coef_b;
    d1_nxt.ma      = coef_a[COEF_W-1] ? (~coef_a + 1'b1) : coef_a;
    d1_nxt.mb      = coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
    d1_nxt.mc      = coef_c[COEF_W-1] ? (~coef_c + 1'b1) : coef_c;
    d1_nxt.za      = d1_nxt.ma < tol_x;
    d1_nxt.zb      = d1_nxt.mb < tol_x;
    d1_nxt.zc      = d1_nxt.mc < tol_x;
    d1_nxt.lin_neg = (coef_c != '0) && (coef_c[COEF_W-1] == coef_b[COEF_W-1]);
  end

  // stage three: discriminant and classification
  always_comb begin
    bb_x  = DISC_W'(bb_r);
    ac4_x = {ac_r, 2'b00};
    if (d2_r.a_neg != d2_r.c_neg) begin
      rad_nxt = bb_x + ac4_x;
      pos     = rad_nxt != '0;
    end else if (bb_x > ac4_x) begin
      rad_nxt = bb_x - ac4_x;
      pos     = 1'b1;
    end else begin
      rad_nxt = ac4_x - bb_x;
      pos     = 1'b0;
    end
    if (d2_r.za) begin
      if (d2_r.zb) side_nxt.code = d2_r.zc ? CASE_INFINITE : CASE_NONE;
      else         side_nxt.code = CASE_LINEAR;
    end else if (pos) begin
      side_nxt.code = CASE_TWO;
    end else if (rad_nxt < DISC_W'(disc_tol)) begin
      side_nxt.code = CASE_DOUBLE;
    end else begin
      side_nxt.code = CASE_NO_REAL;
    end
    side_nxt.b       = d2_r.b;
    side_nxt.a_neg   = d2_r.a_neg;
    side_nxt.ma      = d2_r.ma;
    side_nxt.mb      = d2_r.mb;
    side_nxt.mc      = d2_r.mc;
    side_nxt.lin_neg = d2_r.lin_neg;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload registers, stage two holds the products
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= d1_nxt;
      d2_r   <= d1_r;
      bb_r   <= d1_r.mb * d1_r.mb;
      ac_r   <= d1_r.ma * d1_r.mc;
      rad_r  <= rad_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_rad   = rad_r;
  assign out_side  = side_r;

endmodule

>>> sv/qrs_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage
// depends on qrs_pkg
module qrs_sqrt_pipe import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DISC_W-1:0] in_rad,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic              v_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [DISC_W-1:0] rad_r  [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              p_v;
    logic [REM_W-1:0]  p_rem;
    logic [ROOT_W-1:0] p_root;
    logic [DISC_W-1:0] p_rad;
    side_t             p_side;
    logic [REM_W-1:0]  r2, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = in_rad;
      assign p_side = in_side;
    end else begin : g_next
      assign p_v    = v_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_rad  = rad_r[k-1];
      assign p_side = side_r[k-1];
    end

    // bring down two radicand bits and try the next root bit
    assign r2    = {p_rem[REM_W-3:0], p_rad[DISC_W-1 -: 2]};
    assign trial = REM_W'({p_root, 2'b01});
    assign ge    = r2 >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (r2 - trial) : r2;
        root_r[k] <= {p_root[ROOT_W-2:0], ge};
        rad_r[k]  <= p_rad << 2;
        side_r[k] <= p_side;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

>>> sv/qrs_div_pipe.sv
// pipelined restoring divider, two lanes sharing a divisor, one quotient bit per stage
// depends on qrs_pkg
module qrs_div_pipe import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num1,
  input  logic [NUM_W-1:0]  in_num2,
  input  logic [DEN_W-1:0]  in_den,
  input  dside_t            in_side,
  output logic              out_valid,
  output logic [DIVD_W-1:0] out_q1,
  output logic [DIVD_W-1:0] out_q2,
  output dside_t            out_side
);

  logic              v_r    [DIVD_W];
  logic [DEN_W-1:0]  rem1_r [DIVD_W];
  logic [DEN_W-1:0]  rem2_r [DIVD_W];
  logic [DIVD_W-1:0] nq1_r  [DIVD_W];
  logic [DIVD_W-1:0] nq2_r  [DIVD_W];
  logic [DEN_W-1:0]  den_r  [DIVD_W];
  dside_t            side_r [DIVD_W];

  // one step: {remainder, shifted dividend with new quotient bit}
  function automatic logic [DEN_W+DIVD_W-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                       input logic [DIVD_W-1:0] nq,
                                                       input logic [DEN_W-1:0] den);
    logic [DEN_W:0] r2, diff;
    logic           ge;
    r2   = {rem, nq[DIVD_W-1]};
    diff = r2 - {1'b0, den};
    ge   = r2 >= {1'b0, den};
    return {ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0], nq[DIVD_W-2:0], ge};
  endfunction

  for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
    logic              p_v;
    logic [DEN_W-1:0]  p_rem1, p_rem2, p_den;
    logic [DIVD_W-1:0] p_nq1, p_nq2;
    dside_t            p_side;

    if (k == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_rem1 = '0;
      assign p_rem2 = '0;
      assign p_nq1  = {in_num1, {FRAC_W{1'b0}}};
      assign p_nq2  = {in_num2, {FRAC_W{1'b0}}};
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_next
      assign p_v    = v_r[k-1];
      assign p_rem1 = rem1_r[k-1];
      assign p_rem2 = rem2_r[k-1];
      assign p_nq1  = nq1_r[k-1];
      assign p_nq2  = nq2_r[k-1];
      assign p_den  = den_r[k-1];
      assign p_side = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        {rem1_r[k], nq1_r[k]} <= div_step(p_rem1, p_nq1, p_den);
        {rem2_r[k], nq2_r[k]} <= div_step(p_rem2, p_nq2, p_den);
        den_r[k]              <= p_den;
        side_r[k]             <= p_side;
      end
    end
  end

  assign out_valid = v_r[DIVD_W-1];
  assign out_q1    = nq1_r[DIVD_W-1];
  assign out_q2    = nq2_r[DIVD_W-1];
  assign out_side  = side_r[DIVD_W-1];

endmodule

>>> sv/quadratic_root_solver_top.sv
// top level of the quadratic root solver: config registers, numerator and output stages
// depends on qrs_pkg, qrs_front, qrs_sqrt_pipe, qrs_div_pipe
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | coef_a, coef_b, coef_c
//  out_    | out | out_tvalid/out_tready | case_code, root_one, root_two, saturated
//  cfg_    | in  | cfg_we                | cfg_addr, cfg_wdata
//
// one word accepted per cycle while the output is not stalled; 3 front stages, 33 square
// root stages, 1 numerator stage, 51 divider stages, 1 output register
// synchronous active-low reset clears all valid bits and loads tolerance defaults
// a stall at the output freezes the whole pipeline; in_tready follows out_tready
// whenever the output register is full
module quadratic_root_solver_top import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // coef_a, coef_b, coef_c
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // case_code, root_one, root_two, saturated, zero pad
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic [CTOL_W-1:0] coef_tol_r;
  logic [DTOL_W-1:0] disc_tol_r;
  logic              adv;

  logic              f_valid;
  logic [DISC_W-1:0] f_rad;
  side_t             f_side;
  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  side_t             s_side;

  logic              nv_r;
  logic [NUM_W-1:0]  n1_r, n1_nxt, n2_r, n2_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  dside_t            ds_r, ds_nxt;
  logic [NUM_W-1:0]  nb, sx, n1s, n2s;

  logic              d_valid;
  logic [DIVD_W-1:0] q1, q2;
  dside_t            d_side;
  logic [COEF_W:0]   c1, c2;

  logic              ov_r;
  case_code_t        code_r;
  logic [COEF_W-1:0] r1_r, r1_nxt, r2_r, r2_nxt;
  logic              sat_r, sat_nxt;

  // pipeline moves whenever the output register can take a word
  assign adv       = !ov_r || out_tready;
  assign in_tready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_tol_r <= CTOL_W'(7);
      disc_tol_r <= DTOL_W'(429497);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_COEF_TOL: coef_tol_r <= cfg_wdata[CTOL_W-1:0];
        REG_DISC_TOL: disc_tol_r <= cfg_wdata[DTOL_W-1:0];
      endcase
    end
  end

  qrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .coef_a   (in_tdata[COEF_W-1:0]),
    .coef_b   (in_tdata[2*COEF_W-1:COEF_W]),
    .coef_c   (in_tdata[3*COEF_W-1:2*COEF_W]),
    .coef_tol (coef_tol_r),
    .disc_tol (disc_tol_r),
    .out_valid(f_valid),
    .out_rad  (f_rad),
    .out_side (f_side)
  );

  qrs_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (f_valid),
    .in_rad   (f_rad),
    .in_side  (f_side),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_side (s_side)
  );

  // numerators, divisor and root signs
  always_comb begin
    sx  = (s_side.code == CASE_TWO) ? NUM_W'(s_root) : '0;
    nb  = NUM_W'(0) - NUM_W'(s_side.b);
    n1s = nb + sx;
    n2s = nb - sx;
    ds_nxt.code = s_side.code;
    if (s_side.code == CASE_LINEAR) begin
      n1_nxt      = NUM_W'(s_side.mc);
      n2_nxt      = '0;
      den_nxt     = DEN_W'(s_side.mb);
      ds_nxt.neg1 = s_side.lin_neg;
      ds_nxt.neg2 = 1'b0;
    end else begin
      n1_nxt      = n1s[NUM_W-1] ? (~n1s + 1'b1) : n1s;
      n2_nxt      = n2s[NUM_W-1] ? (~n2s + 1'b1) : n2s;
      den_nxt     = {s_side.ma, 1'b0};
      ds_nxt.neg1 = n1s[NUM_W-1] != s_side.a_neg;
      ds_nxt.neg2 = n2s[NUM_W-1] != s_side.a_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (adv) begin
      nv_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r  <= n1_nxt;
      n2_r  <= n2_nxt;
      den_r <= den_nxt;
      ds_r  <= ds_nxt;
    end
  end

  qrs_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (nv_r),
    .in_num1  (n1_r),
    .in_num2  (n2_r),
    .in_den   (den_r),
    .in_side  (ds_r),
    .out_valid(d_valid),
    .out_q1   (q1),
    .out_q2   (q2),
    .out_side (d_side)
  );

  // clipping and selection of the roots that the case uses
  always_comb begin
    c1 = clip_root(q1, d_side.neg1);
    c2 = clip_root(q2, d_side.neg2);
    r1_nxt  = '0;
    r2_nxt  = '0;
    sat_nxt = 1'b0;
    case (d_side.code)
      CASE_LINEAR, CASE_DOUBLE: begin
        r1_nxt  = c1[COEF_W-1:0];
        sat_nxt = c1[COEF_W];
      end
      CASE_TWO: begin
        r1_nxt  = c1[COEF_W-1:0];
        r2_nxt  = c2[COEF_W-1:0];
        sat_nxt = c1[COEF_W] || c2[COEF_W];
      end
      default: begin
        r1_nxt  = '0;
        r2_nxt  = '0;
        sat_nxt = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code_r <= d_side.code;
      r1_r   <= r1_nxt;
      r2_r   <= r2_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_W'({sat_r, r2_r, r1_r, code_r});

endmodule

>>> sv/qrs_checker.sv
// port-level checks for the quadratic root solver, bound to the top level
// depends on qrs_pkg and quadratic_root_solver_top
module qrs_checker import qrs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  logic [2:0]        code;
  logic [COEF_W-1:0] r1, r2;
  logic              sat;

  assign code = out_tdata[2:0];
  assign r1   = out_tdata[COEF_W+2:3];
  assign r2   = out_tdata[2*COEF_W+2:COEF_W+3];
  assign sat  = out_tdata[2*COEF_W+3];

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // an empty output register never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // cases without roots give zero roots and no clipping
  a_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (code == CASE_INFINITE || code == CASE_NONE || code == CASE_NO_REAL)
    |-> r1 == '0 && r2 == '0 && !sat)
    else $error("roots reported for a rootless case");

  // second root only for two distinct roots
  a_root_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && code != CASE_TWO |-> r2 == '0)
    else $error("second root outside the two-root case");

  // padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:OUT_RAW] == '0)
    else $error("nonzero padding in output word");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (.*);
